/* rtl/core/ucf_pkg.sv */
// package of shared widths, register codes and decode helpers for the utf8 codepoint filter
package ucf_pkg;

    localparam int CP_W     = 21;
    localparam int ASCII_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int CFG_IX_W = 3;
    localparam int MAX_RES  = 4;
    localparam int RES_CNT_W = 3;
    localparam int RES_IX_W  = 2;

    localparam logic [CFG_IX_W-1:0] CFG_KEEP_LIMIT   = 3'd0;
    localparam logic [CFG_IX_W-1:0] CFG_BAND_LOW     = 3'd1;
    localparam logic [CFG_IX_W-1:0] CFG_BAND_HIGH    = 3'd2;
    localparam logic [CFG_IX_W-1:0] CFG_STRIP_FIRST  = 3'd3;
    localparam logic [CFG_IX_W-1:0] CFG_STRIP_SECOND = 3'd4;

    localparam logic [CP_W-1:0]    RST_KEEP_LIMIT   = 21'h00024F;
    localparam logic [CP_W-1:0]    RST_BAND_LOW     = 21'h002000;
    localparam logic [CP_W-1:0]    RST_BAND_HIGH    = 21'h00206F;
    localparam logic [ASCII_W-1:0] RST_STRIP_FIRST  = 7'h2A;
    localparam logic [ASCII_W-1:0] RST_STRIP_SECOND = 7'h23;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CP_W-1:0]   t_cp;

    function automatic logic [2:0] lead_length(input t_byte c);
        logic [2:0] len;
        len = 3'd1;
        if ((c & 8'hE0) == 8'hC0) begin
            len = 3'd2;
        end else if ((c & 8'hF0) == 8'hE0) begin
            len = 3'd3;
        end else if ((c & 8'hF8) == 8'hF0) begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic is_strip(input t_byte c, input logic [ASCII_W-1:0] s1,
                                      input logic [ASCII_W-1:0] s2);
        return (c == {1'b0, s1}) || (c == {1'b0, s2});
    endfunction

    function automatic t_cp cp_decode(input logic [2:0] len, input t_byte b0, input t_byte b1,
                                      input t_byte b2, input t_byte b3);
        t_cp cp;
        case (len)
            3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = {13'd0, b0};
        endcase
        return cp;
    endfunction

endpackage

/* rtl/core/utf8_codepoint_filter.sv */
// top level of the utf8 codepoint filter: sequence assembly, decode, keep test and result buffer
//
// channel   dir  handshake                 payload
// s (in)    in   i_s_tvalid / o_s_tready   tdata in_byte, tlast in_last
// m (out)   out  o_m_tvalid / i_m_tready   tdata out_byte, tlast run_last,
//                                          tuser {text_end, byte_valid}
// cfg       in   i_cfg_valid / o_cfg_ready index 0..4, data 21 bits
//
// one input byte is decoded in the cycle it is accepted and its results land in a
// four-entry buffer; results leave one per cycle while the output is not stalled, so a byte
// with results holds the input until its last result leaves, and a byte with none leaves it ready
// the next byte is taken in the same cycle as the last buffered result leaves
// synchronous reset clears the held sequence and the buffer and loads the registers' reset values
// stalls on the output hold the buffer and back-pressure the input
module utf8_codepoint_filter
    import ucf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,     // [7:0] in_byte
    input  logic                i_s_tlast,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [7:0]          o_m_tdata,     // [7:0] out_byte
    output logic [1:0]          o_m_tuser,     // [0] byte_valid, [1] text_end
    output logic                o_m_tlast,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [CP_W-1:0]     i_cfg_data
);

    logic [CP_W-1:0]    r_keep_limit, r_band_low, r_band_high;
    logic [ASCII_W-1:0] r_strip_first, r_strip_second;

    t_byte          r_pend [3];
    logic [1:0]     r_pcount, n_pcount;
    logic [2:0]     r_seqlen, n_seqlen;

    t_byte                 r_obyte [MAX_RES];
    t_byte                 n_obyte [MAX_RES];
    logic [RES_CNT_W-1:0]  r_ocnt, n_ocnt;
    logic [RES_IX_W-1:0]   r_oidx;
    logic                  r_marker, n_marker;
    logic                  r_end;

    logic       s_acc, m_acc, last_ent;
    t_byte      b, t0;
    t_byte      w [MAX_RES];
    logic [2:0] n_len;
    logic       complete, trunc, pair, keep, e0, e1;
    t_cp        cp;
    logic [RES_CNT_W-1:0] k;

    assign o_cfg_ready = 1'b1;

    assign last_ent   = ({1'b0, r_oidx} == (r_ocnt - 3'd1));
    assign o_m_tvalid = (r_ocnt != '0);
    assign m_acc      = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_ocnt == '0) || (i_m_tready && last_ent);
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign o_m_tdata  = r_obyte[r_oidx];
    assign o_m_tlast  = last_ent;
    assign o_m_tuser  = {r_end && last_ent, !r_marker};

    assign b     = i_s_tdata;
    assign n_len = {1'b0, r_pcount} + 3'd1;

    always_comb begin
        w[0] = (r_pcount > 2'd0) ? r_pend[0] : b;
        w[1] = (r_pcount > 2'd1) ? r_pend[1] : b;
        w[2] = (r_pcount > 2'd2) ? r_pend[2] : b;
        w[3] = b;
    end

    assign complete = (r_pcount != '0) && (n_len >= r_seqlen);
    assign trunc    = (r_pcount != '0) && i_s_tlast && !complete;
    assign pair     = trunc && (r_pcount == 2'd2) && (lead_length(r_pend[1]) == 3'd2);

    assign cp   = pair ? cp_decode(3'd2, r_pend[1], b, '0, '0)
                       : cp_decode(r_seqlen, w[0], w[1], w[2], w[3]);
    assign keep = (cp <= r_keep_limit) || ((cp >= r_band_low) && (cp <= r_band_high));

    // tail of a cut-short sequence: the bytes after the dropped lead
    assign t0 = (r_pcount == 2'd1) ? b : r_pend[1];
    assign e0 = !is_strip(t0, r_strip_first, r_strip_second) && !t0[7];
    assign e1 = (r_pcount == 2'd2) && !pair
                && !is_strip(b, r_strip_first, r_strip_second) && !b[7];

    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            n_obyte[i] = '0;
        end
        k        = '0;
        n_marker = 1'b0;
        n_pcount = r_pcount;
        n_seqlen = r_seqlen;
        if (r_pcount == '0) begin
            if (!is_strip(b, r_strip_first, r_strip_second)) begin
                if (!b[7]) begin
                    n_obyte[0] = b;
                    k          = 3'd1;
                end else if (!i_s_tlast && (lead_length(b) > 3'd1)) begin
                    n_pcount = 2'd1;
                    n_seqlen = lead_length(b);
                end
            end
        end else if (complete) begin
            if (keep) begin
                n_obyte = w;
                k       = r_seqlen;
            end
            n_pcount = '0;
            n_seqlen = 3'd1;
        end else if (trunc) begin
            if (pair) begin
                if (keep) begin
                    n_obyte[0] = r_pend[1];
                    n_obyte[1] = b;
                    k          = 3'd2;
                end
            end else begin
                if (e0) begin
                    n_obyte[0] = t0;
                    k          = 3'd1;
                end
                if (e1) begin
                    n_obyte[k[1:0]] = b;
                    k               = k + 3'd1;
                end
            end
        end else begin
            n_pcount = n_len[1:0];
        end
        if (i_s_tlast) begin
            n_pcount = '0;
            n_seqlen = 3'd1;
            if (k == '0) begin
                n_marker = 1'b1;
                k        = 3'd1;
            end
        end
        n_ocnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_limit   <= RST_KEEP_LIMIT;
            r_band_low     <= RST_BAND_LOW;
            r_band_high    <= RST_BAND_HIGH;
            r_strip_first  <= RST_STRIP_FIRST;
            r_strip_second <= RST_STRIP_SECOND;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEEP_LIMIT:   r_keep_limit   <= i_cfg_data;
                CFG_BAND_LOW:     r_band_low     <= i_cfg_data;
                CFG_BAND_HIGH:    r_band_high    <= i_cfg_data;
                CFG_STRIP_FIRST:  r_strip_first  <= i_cfg_data[ASCII_W-1:0];
                CFG_STRIP_SECOND: r_strip_second <= i_cfg_data[ASCII_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= '0;
            r_seqlen <= 3'd1;
        end else if (s_acc) begin
            r_pcount <= n_pcount;
            r_seqlen <= n_seqlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && (r_pcount != '0) && !complete && !i_s_tlast) begin
            r_pend[r_pcount] <= b;
        end else if (s_acc && (r_pcount == '0)) begin
            r_pend[0] <= b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0;
            r_oidx <= '0;
        end else if (s_acc) begin
            r_ocnt <= n_ocnt;
            r_oidx <= '0;
        end else if (m_acc) begin
            if (last_ent) begin
                r_ocnt <= '0;
                r_oidx <= '0;
            end else begin
                r_oidx <= r_oidx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_obyte  <= n_obyte;
            r_marker <= n_marker;
            r_end    <= i_s_tlast;
        end
    end

endmodule

/* rtl/core/ucf_checker.sv */
// port-level checker for the utf8 codepoint filter, bound to the top level
module ucf_checker
    import ucf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [BYTE_W-1:0]   o_m_tdata,
    input logic [1:0]          o_m_tuser,
    input logic                o_m_tlast
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output transaction changed while stalled");

    // a bare end marker is zero and closes both the run and the text
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tlast && o_m_tuser[1] && (o_m_tdata == '0))
        else $error("bare marker without end flags");

    // text end only on the last result of a run
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tlast)
        else $error("text end without run end");

    // no output transaction offered right after a reset cycle
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind utf8_codepoint_filter ucf_checker u_ucf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

/* dv/ucf_check_pkg.sv */
// scoreboard class for the utf8 codepoint filter: byte filter prediction and result checking
package ucf_check_pkg;
    import ucf_pkg::*;

    typedef struct {
        t_byte data;
        logic  kept;
        logic  run_last;
        logic  text_end;
    } ucf_result_t;

    class ucf_filter_scoreboard;
        t_cp                keep_limit;
        t_cp                band_low;
        t_cp                band_high;
        logic [ASCII_W-1:0] strip_first;
        logic [ASCII_W-1:0] strip_second;
        t_byte              held[3];
        int                 held_cnt;
        int                 seq_len;
        ucf_result_t        step_results[$];
        ucf_result_t        expected_results[$];
        int                 errors;

        function new();
            keep_limit   = RST_KEEP_LIMIT;
            band_low     = RST_BAND_LOW;
            band_high    = RST_BAND_HIGH;
            strip_first  = RST_STRIP_FIRST;
            strip_second = RST_STRIP_SECOND;
            held_cnt     = 0;
            seq_len      = 1;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IX_W-1:0] index, t_cp value);
            case (index)
                CFG_KEEP_LIMIT:   keep_limit = value;
                CFG_BAND_LOW:     band_low = value;
                CFG_BAND_HIGH:    band_high = value;
                CFG_STRIP_FIRST:  strip_first = value[ASCII_W-1:0];
                CFG_STRIP_SECOND: strip_second = value[ASCII_W-1:0];
                default: ;
            endcase
        endfunction

        function int seq_bytes(t_byte c);
            casez (c)
                8'b110?????: return 2;
                8'b1110????: return 3;
                8'b11110???: return 4;
                default:     return 1;
            endcase
        endfunction

        function bit is_marker(t_byte c);
            return (c == {1'b0, strip_first}) || (c == {1'b0, strip_second});
        endfunction

        function void emit(t_byte b);
            ucf_result_t r;
            r.data     = b;
            r.kept     = 1'b1;
            r.run_last = 1'b0;
            r.text_end = 1'b0;
            step_results.push_back(r);
        endfunction

        // filter a stretch whose end is known
        function void filter_span(t_byte span[$]);
            int    i;
            int    len;
            t_byte c;
            t_cp   cp;
            i = 0;
            while (i < span.size()) begin
                c   = span[i];
                len = seq_bytes(c);
                if (is_marker(c)) begin
                    i++;
                end else if (len > 1 && i + len <= span.size()) begin
                    if (len == 2) begin
                        cp = t_cp'(c & 8'h1F);
                    end else if (len == 3) begin
                        cp = t_cp'(c & 8'h0F);
                    end else begin
                        cp = t_cp'(c & 8'h07);
                    end
                    for (int k = 1; k < len; k++) begin
                        cp = (cp << 6) | t_cp'(span[i + k] & 8'h3F);
                    end
                    if (cp <= keep_limit || (cp >= band_low && cp <= band_high)) begin
                        for (int k = 0; k < len; k++) begin
                            emit(span[i + k]);
                        end
                    end
                    i += len;
                end else begin
                    if (!c[7]) begin
                        emit(c);
                    end
                    i++;
                end
            end
        endfunction

        function void note_byte(t_byte b, logic last);
            t_byte       span[$];
            ucf_result_t marker;
            step_results = {};
            if (held_cnt == 0) begin
                if (last) begin
                    span.push_back(b);
                    filter_span(span);
                end else if (!is_marker(b)) begin
                    if (seq_bytes(b) > 1) begin
                        held[0]  = b;
                        held_cnt = 1;
                        seq_len  = seq_bytes(b);
                    end else if (!b[7]) begin
                        emit(b);
                    end
                end
            end else begin
                for (int i = 0; i < held_cnt; i++) begin
                    span.push_back(held[i]);
                end
                span.push_back(b);
                if (last || span.size() >= seq_len) begin
                    filter_span(span);
                    held_cnt = 0;
                    seq_len  = 1;
                end else begin
                    held[held_cnt] = b;
                    held_cnt++;
                end
            end
            if (last) begin
                if (step_results.size() == 0) begin
                    marker.data     = '0;
                    marker.kept     = 1'b0;
                    marker.run_last = 1'b0;
                    marker.text_end = 1'b0;
                    step_results.push_back(marker);
                end
                step_results[step_results.size() - 1].text_end = 1'b1;
                held_cnt = 0;
                seq_len  = 1;
            end
            if (step_results.size() > 0) begin
                step_results[step_results.size() - 1].run_last = 1'b1;
            end
            foreach (step_results[i]) begin
                expected_results.push_back(step_results[i]);
            end
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void check_result(t_byte data, logic [1:0] user, logic last);
            ucf_result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected transaction: out_byte %h byte_valid %b run_last %b text_end %b",
                         $time, data, user[0], last, user[1]);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if ({data, user[0], last, user[1]} !==
                {want.data, want.kept, want.run_last, want.text_end}) begin
                $display("%0t: mismatch: expected out_byte %h byte_valid %b run_last %b text_end %b",
                         $time, want.data, want.kept, want.run_last, want.text_end);
                $display("%0t:           actual out_byte %h byte_valid %b run_last %b text_end %b",
                         $time, data, user[0], last, user[1]);
                errors++;
            end
        endfunction
    endclass

endpackage

/* dv/utf8_codepoint_filter_test.sv */
// testbench top for the utf8 codepoint filter: directed and random texts under several settings
module utf8_codepoint_filter_test;
    import ucf_pkg::*;
    import ucf_check_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 60;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata;
    logic                i_s_tlast;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [7:0]          o_m_tdata;
    logic [1:0]          o_m_tuser;
    logic                o_m_tlast;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IX_W-1:0] i_cfg_index;
    logic [CP_W-1:0]     i_cfg_data;
    logic                any_xfer;

    ucf_filter_scoreboard filter_sb = new();
    t_byte                text_q[$];
    int                   bytes_sent;
    bit                   in_burst;
    bit                   out_burst;

    utf8_codepoint_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    assign any_xfer = (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                      (i_cfg_valid && o_cfg_ready);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                filter_sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (i_s_tvalid && o_s_tready) begin
                filter_sb.note_byte(i_s_tdata, i_s_tlast);
            end
            if (o_m_tvalid && i_m_tready) begin
                filter_sb.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (any_xfer) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 17);
    endfunction

    // result side: random stall before each transaction
    initial begin
        int stall;
        i_m_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = draw_wait(out_burst);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic send_byte(input t_byte b, input logic last);
        int gap;
        gap = draw_wait(in_burst);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (filter_sb.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IX_W-1:0] index, input t_cp value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input t_cp keep, input t_cp lo, input t_cp hi,
                             input logic [ASCII_W-1:0] s1, input logic [ASCII_W-1:0] s2);
        drain();
        write_reg(CFG_KEEP_LIMIT, keep);
        write_reg(CFG_BAND_LOW, lo);
        write_reg(CFG_BAND_HIGH, hi);
        write_reg(CFG_STRIP_FIRST, t_cp'(s1));
        write_reg(CFG_STRIP_SECOND, t_cp'(s2));
    endtask

    function automatic t_byte tail_byte();
        if ($urandom_range(0, 7) == 0) begin
            return t_byte'($urandom_range(0, 255));
        end
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    function automatic t_byte lead_of(int len);
        case (len)
            2:       return {3'b110, 5'($urandom_range(0, 31))};
            3:       return {4'b1110, 4'($urandom_range(0, 15))};
            default: return {5'b11110, 3'($urandom_range(0, 7))};
        endcase
    endfunction

    function automatic t_byte marker_byte();
        return $urandom_range(0, 1) ? {1'b0, filter_sb.strip_first}
                                    : {1'b0, filter_sb.strip_second};
    endfunction

    // mostly well-formed characters, some stray, noisy and broken sequences
    task automatic make_text();
        int kind;
        int len;
        text_q = {};
        repeat ($urandom_range(1, 10)) begin
            kind = $urandom_range(0, 19);
            if (kind < 7) begin
                if ($urandom_range(0, 3) == 0) begin
                    text_q.push_back(marker_byte());
                end else begin
                    text_q.push_back(t_byte'($urandom_range(0, 127)));
                end
            end else if (kind < 16) begin
                len = 2 + (kind - 7) / 3;
                text_q.push_back(lead_of(len));
                repeat (len - 1) text_q.push_back(tail_byte());
            end else if (kind == 16) begin
                text_q.push_back(t_byte'($urandom_range(128, 255)));
            end else if (kind == 17) begin
                text_q.push_back(t_byte'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(2, 4);
                text_q.push_back(lead_of(len));
                repeat (len - 1) begin
                    if ($urandom_range(0, 2) == 0) begin
                        text_q.push_back(marker_byte());
                    end else begin
                        text_q.push_back(t_byte'($urandom_range(0, 255)));
                    end
                end
            end
        end
        // truncated sequence at the end of the text
        if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(2, 4);
            text_q.push_back(lead_of(len));
            repeat ($urandom_range(0, len - 2)) text_q.push_back(tail_byte());
        end
    endtask

    task automatic run_phase(input int target);
        while (bytes_sent < target) begin
            make_text();
            in_burst  = ($urandom_range(0, 4) == 0);
            out_burst = ($urandom_range(0, 4) == 0);
            send_text();
            if ($urandom_range(0, 9) == 0) begin
                drain();
            end
        end
    endtask

    initial begin
        int band_lo;
        int band_hi;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_KEEP_LIMIT;
        i_cfg_data  = '0;
        bytes_sent  = 0;
        in_burst    = 1'b0;
        out_burst   = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ascii, markers, kept and dropped sequences, strays, marker inside a sequence
        text_q = '{8'h41, 8'h2A, 8'h23, 8'hC2, 8'hA9, 8'hE2, 8'h80, 8'h94, 8'hE4, 8'hB8,
                   8'hAD, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF, 8'hC2, 8'h2A, 8'h00,
                   8'h7F};
        send_text();
        // truncated four-byte sequence whose tail holds a complete two-byte one
        text_q = '{8'hF0, 8'hC2, 8'h80};
        send_text();
        // text of one stripped byte: bare end marker
        text_q = '{8'h2A};
        send_text();

        configure(21'h1FFFFF, 21'h1FFFFF, 21'h000000, 7'h00, 7'h7F);
        run_phase(25 + ITEMS_PER_PHASE);
        configure(21'h000000, 21'h000080, 21'h0007FF, 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
        run_phase(25 + 2 * ITEMS_PER_PHASE);
        // empty band
        configure(21'h00007F, 21'h000001, 21'h000000, 7'h20, 7'h41);
        run_phase(25 + 3 * ITEMS_PER_PHASE);
        band_lo = $urandom_range(0, 21'h1FFFFF);
        band_hi = band_lo + $urandom_range(0, 21'h1FFFFF - band_lo);
        configure(t_cp'($urandom_range(0, 16'hFFFF)), t_cp'(band_lo), t_cp'(band_hi),
                  7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        run_phase(25 + 4 * ITEMS_PER_PHASE);

        drain();
        repeat (16) @(negedge i_clk);
        if (filter_sb.errors == 0 && filter_sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
